>>> design/ptc_pkg.sv
// ----------------------------------------------------------------------------
// Pressure and temperature compensation package
// Shared widths, register indexes, payload types and arithmetic helpers.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 64;
    localparam int DivSteps = 32;

    localparam logic [CfgIdxW-1:0] REG_TEMP_COEFFS  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_A      = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_B      = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESS_NINE   = 2'd3;

    typedef struct packed {
        logic [19:0] temp_sample;
        logic [19:0] press_sample;
    } ptc_in_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_pa;
        logic signed [31:0] fine_temperature;
        logic               divisor_zero;
    } ptc_out_t;

    // Fields that travel beside the divider.
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
        logic        zero;
        logic        big;
    } ptc_side_t;

    function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned s);
        logic signed [31:0] t;
        begin
            t = v;
            return 32'(t >>> s);
        end
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        begin
            return {{16{v[15]}}, v};
        end
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        begin
            p = a * b;
            return p[31:0];
        end
    endfunction

endpackage

>>> design/ptc_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload of type T with a source and a sink modport.
// ----------------------------------------------------------------------------
interface ptc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/ptc_divider.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned 32/32 division, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module ptc_divider
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        in_valid,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    input  ptc_side_t   in_side,
    output logic        out_valid,
    output logic [31:0] quotient,
    output ptc_side_t   out_side
);

    logic [DivSteps-1:0]      vld_reg;
    logic [31:0]              rem_reg [DivSteps];
    logic [31:0]              quo_reg [DivSteps];
    logic [31:0]              dvs_reg [DivSteps];
    ptc_side_t                side_reg [DivSteps];

    for (genvar i = 0; i < DivSteps; i++)
    begin : g_step
        logic        cur_vld;
        logic [31:0] cur_rem;
        logic [31:0] cur_quo;
        logic [31:0] cur_dvs;
        ptc_side_t   cur_side;
        logic [32:0] trial;
        logic [32:0] shifted;

        if (i == 0)
        begin : g_first
            assign cur_vld  = in_valid;
            assign cur_rem  = '0;
            assign cur_quo  = dividend;
            assign cur_dvs  = divisor;
            assign cur_side = in_side;
        end
        else
        begin : g_next
            assign cur_vld  = vld_reg[i-1];
            assign cur_rem  = rem_reg[i-1];
            assign cur_quo  = quo_reg[i-1];
            assign cur_dvs  = dvs_reg[i-1];
            assign cur_side = side_reg[i-1];
        end

        assign shifted = {cur_rem, cur_quo[31]};
        assign trial   = shifted - {1'b0, cur_dvs};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[i] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (!trial[32])
                begin
                    rem_reg[i] <= trial[31:0];
                    quo_reg[i] <= {cur_quo[30:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= shifted[31:0];
                    quo_reg[i] <= {cur_quo[30:0], 1'b0};
                end
                dvs_reg[i]  <= cur_dvs;
                side_reg[i] <= cur_side;
            end
        end
    end

    assign out_valid = vld_reg[DivSteps-1];
    assign quotient  = quo_reg[DivSteps-1];
    assign out_side  = side_reg[DivSteps-1];

endmodule

>>> design/pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// Pressure and temperature compensation
// Computes fine temperature, temperature and pressure from raw samples.
//
//   Channel  Direction  Payload
//   in_s     sink       temp_sample, press_sample
//   out_s    source     temperature_centi, pressure_pa, fine_temperature,
//                       divisor_zero
//   cfg      write      cfg_we, cfg_index, cfg_data
//
// One sample pair is taken every cycle unless the stages hold; a result is
// offered through 43 register stages: seven arithmetic stages,
// the 32-stage divider, three correction stages and the output register.
// All stages advance together and hold while the output register is full
// and not taken. Reset clears valid bits and calibration registers.
// ----------------------------------------------------------------------------
module pressure_temp_compensation
    import ptc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    ptc_stream_if.sink          in_s,
    ptc_stream_if.source        out_s
);

    logic [47:0] tc_reg;
    logic [63:0] pa_reg;
    logic [63:0] pb_reg;
    logic [15:0] p9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= '0;
            pa_reg <= '0;
            pb_reg <= '0;
            p9_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEMP_COEFFS: tc_reg <= cfg_data[47:0];
                REG_PRESS_A:     pa_reg <= cfg_data;
                REG_PRESS_B:     pb_reg <= cfg_data;
                REG_PRESS_NINE:  p9_reg <= cfg_data[15:0];
            endcase
        end
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, tc_reg[15:0]};
    assign t2 = sx16(tc_reg[31:16]);
    assign t3 = sx16(tc_reg[47:32]);
    assign p1 = {16'd0, pa_reg[15:0]};
    assign p2 = sx16(pa_reg[31:16]);
    assign p3 = sx16(pa_reg[47:32]);
    assign p4 = sx16(pa_reg[63:48]);
    assign p5 = sx16(pb_reg[15:0]);
    assign p6 = sx16(pb_reg[31:16]);
    assign p7 = sx16(pb_reg[47:32]);
    assign p8 = sx16(pb_reg[63:48]);
    assign p9 = sx16(p9_reg);

    logic out_valid_reg;
    logic adv;
    assign adv      = !out_valid_reg || out_s.ready;
    assign in_s.ready = adv;

    // Stage 1: temperature products.
    logic        v1_reg;
    logic [31:0] s1a_reg, s1d2_reg, s1p_reg;
    logic [31:0] d1;
    assign d1 = {16'd0, in_s.data.temp_sample[19:4]} - t1;

    // Stage 2: fine temperature partial.
    logic        v2_reg;
    logic [31:0] s2a_reg, s2b_reg, s2p_reg;
    // Stage 3: fine and temperature.
    logic        v3_reg;
    logic [31:0] s3fine_reg, s3t5_reg, s3p_reg;
    // Stage 4: pressure var1 and square.
    logic        v4_reg;
    logic [31:0] s4fine_reg, s4temp_reg, s4a_reg, s4sq_reg, s4p_reg;
    // Stage 5: products of var1.
    logic        v5_reg;
    logic [31:0] s5fine_reg, s5temp_reg, s5p_reg;
    logic [31:0] s5b6_reg, s5a5_reg, s5m3_reg, s5m2_reg;
    // Stage 6: combine into var2 and var1.
    logic        v6_reg;
    logic [31:0] s6fine_reg, s6temp_reg, s6p_reg, s6b_reg, s6a_reg;
    // Stage 7: divisor and dividend.
    logic        v7_reg;
    logic [31:0] s7fine_reg, s7temp_reg, s7dvs_reg, s7num_reg;
    logic [31:0] v6a1, v6a;
    logic [31:0] a4;
    assign a4 = sra32(s4a_reg, 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_s.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    assign v6a1 = sra32(sra32(mul32(p3, sra32(s5m3_reg, 13)), 3) + sra32(s5m2_reg, 1), 18);
    assign v6a  = 32'd32768 + v6a1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1a_reg  <= mul32({15'd0, in_s.data.temp_sample[19:3]} - (t1 << 1), t2);
            s1d2_reg <= mul32(d1, d1);
            s1p_reg  <= {12'd0, in_s.data.press_sample};

            s2a_reg <= sra32(s1a_reg, 11);
            s2b_reg <= sra32(mul32(sra32(s1d2_reg, 12), t3), 14);
            s2p_reg <= s1p_reg;

            s3fine_reg <= s2a_reg + s2b_reg;
            s3t5_reg   <= mul32(s2a_reg + s2b_reg, 32'd5) + 32'd128;
            s3p_reg    <= s2p_reg;

            s4fine_reg <= s3fine_reg;
            s4temp_reg <= sra32(s3t5_reg, 8);
            s4a_reg    <= sra32(s3fine_reg, 1) - 32'd64000;
            s4sq_reg   <= mul32(sra32(sra32(s3fine_reg, 1) - 32'd64000, 2),
                                sra32(sra32(s3fine_reg, 1) - 32'd64000, 2));
            s4p_reg    <= s3p_reg;

            s5fine_reg <= s4fine_reg;
            s5temp_reg <= s4temp_reg;
            s5p_reg    <= s4p_reg;
            s5b6_reg   <= mul32(sra32(s4sq_reg, 11), p6);
            s5a5_reg   <= mul32(s4a_reg, p5) << 1;
            s5m3_reg   <= mul32(a4, a4);
            s5m2_reg   <= mul32(p2, s4a_reg);

            s6fine_reg <= s5fine_reg;
            s6temp_reg <= s5temp_reg;
            s6p_reg    <= s5p_reg;
            s6b_reg    <= sra32(s5b6_reg + s5a5_reg, 2) + (p4 << 16);
            s6a_reg    <= v6a;

            s7fine_reg <= s6fine_reg;
            s7temp_reg <= s6temp_reg;
            s7dvs_reg  <= sra32(mul32(s6a_reg, p1), 15);
            s7num_reg  <= mul32((32'd1048576 - s6p_reg) - sra32(s6b_reg, 12), 32'd3125);
        end
    end

    ptc_side_t   side_in, side_out;
    logic [31:0] dividend;
    logic        big;
    logic        dq_valid;
    logic [31:0] quo;

    assign big      = s7num_reg[31];
    assign dividend = big ? s7num_reg : (s7num_reg << 1);
    assign side_in  = '{temp: s7temp_reg, fine: s7fine_reg,
                        zero: (s7dvs_reg == 32'd0), big: big};

    ptc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (adv),
        .in_valid  (v7_reg),
        .dividend  (dividend),
        .divisor   (s7dvs_reg),
        .in_side   (side_in),
        .out_valid (dq_valid),
        .quotient  (quo),
        .out_side  (side_out)
    );

    // Post-division correction stages.
    logic        v8_reg, v9_reg, v10_reg;
    ptc_side_t   s8side_reg, s9side_reg, s10side_reg;
    logic [31:0] s8p_reg, s9p_reg, s9sq_reg, s9b_reg, s10p_reg, s10a_reg, s10b_reg;
    ptc_out_t    out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v8_reg        <= dq_valid;
            v9_reg        <= v8_reg;
            v10_reg       <= v9_reg;
            out_valid_reg <= v10_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8side_reg <= side_out;
            s8p_reg    <= side_out.big ? (quo << 1) : quo;

            s9side_reg <= s8side_reg;
            s9p_reg    <= s8p_reg;
            s9sq_reg   <= mul32({3'd0, s8p_reg[31:3]}, {3'd0, s8p_reg[31:3]}) >> 13;
            s9b_reg    <= sra32(mul32({2'd0, s8p_reg[31:2]}, p8), 13);

            s10side_reg <= s9side_reg;
            s10p_reg    <= s9p_reg;
            s10a_reg    <= sra32(mul32(p9, s9sq_reg), 12);
            s10b_reg    <= s9b_reg;

            out_reg.temperature_centi <= s10side_reg.temp;
            out_reg.fine_temperature  <= s10side_reg.fine;
            out_reg.divisor_zero      <= s10side_reg.zero;
            out_reg.pressure_pa       <= s10side_reg.zero ? 32'd0
                : s10p_reg + sra32(s10a_reg + s10b_reg + p7, 4);
        end
    end

    assign out_s.valid = out_valid_reg;
    assign out_s.data  = out_reg;

endmodule

>>> test/pressure_temp_compensation_tb.sv
// ----------------------------------------------------------------------------
// Pressure and temperature compensation testbench
// Drives raw sample pairs under several calibration settings and flow
// control patterns, predicts each result in the scoreboard and compares
// every output transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
class comp_scoreboard;
    ptc_pkg::ptc_out_t pending[$];
    logic [47:0] tc;
    logic [63:0] pa;
    logic [63:0] pb;
    logic [15:0] p9c;
    int errors;

    function new();
        tc = '0;
        pa = '0;
        pb = '0;
        p9c = '0;
        errors = 0;
    endfunction

    function logic [31:0] asr(logic [31:0] v, int s);
        logic signed [31:0] t;
        t = v;
        return t >>> s;
    endfunction

    function logic [31:0] sext(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function void note_sample(ptc_pkg::ptc_in_t s);
        ptc_pkg::ptc_out_t r;
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, d, sq, fine, p;
        t1 = {16'd0, tc[15:0]};
        t2 = sext(tc[31:16]);
        t3 = sext(tc[47:32]);
        p1 = {16'd0, pa[15:0]};
        p2 = sext(pa[31:16]);
        p3 = sext(pa[47:32]);
        p4 = sext(pa[63:48]);
        p5 = sext(pb[15:0]);
        p6 = sext(pb[31:16]);
        p7 = sext(pb[47:32]);
        p8 = sext(pb[63:48]);
        p9 = sext(p9c);
        a = asr(((32'(s.temp_sample) >> 3) - (t1 << 1)) * t2, 11);
        d = (32'(s.temp_sample) >> 4) - t1;
        b = asr(asr(d * d, 12) * t3, 14);
        fine = a + b;
        r.fine_temperature = fine;
        r.temperature_centi = asr(fine * 32'd5 + 32'd128, 8);
        a = asr(fine, 1) - 32'd64000;
        sq = asr(a, 2) * asr(a, 2);
        b = asr(sq, 11) * p6;
        b = b + ((a * p5) << 1);
        b = asr(b, 2) + (p4 << 16);
        a = asr(asr(p3 * asr(sq, 13), 3) + asr(p2 * a, 1), 18);
        a = asr((32'd32768 + a) * p1, 15);
        if (a == 0)
        begin
            r.pressure_pa = '0;
            r.divisor_zero = 1'b1;
        end
        else
        begin
            p = ((32'd1048576 - 32'(s.press_sample)) - asr(b, 12)) * 32'd3125;
            if (p < 32'h80000000)
                p = (p << 1) / a;
            else
                p = (p / a) * 32'd2;
            a = asr(p9 * ((((p >> 3) * (p >> 3)) >> 13)), 12);
            b = asr((p >> 2) * p8, 13);
            p = p + asr(a + b + p7, 4);
            r.pressure_pa = p;
            r.divisor_zero = 1'b0;
        end
        pending.push_back(r);
    endfunction

    function void check_result(ptc_pkg::ptc_out_t got);
        ptc_pkg::ptc_out_t want;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.temperature_centi !== want.temperature_centi)
        begin
            $display("%0t: temperature_centi expected %0d actual %0d", $time,
                     want.temperature_centi, got.temperature_centi);
            errors++;
        end
        if (got.pressure_pa !== want.pressure_pa)
        begin
            $display("%0t: pressure_pa expected %0d actual %0d", $time,
                     want.pressure_pa, got.pressure_pa);
            errors++;
        end
        if (got.fine_temperature !== want.fine_temperature)
        begin
            $display("%0t: fine_temperature expected %0d actual %0d", $time,
                     want.fine_temperature, got.fine_temperature);
            errors++;
        end
        if (got.divisor_zero !== want.divisor_zero)
        begin
            $display("%0t: divisor_zero expected %0b actual %0b", $time,
                     want.divisor_zero, got.divisor_zero);
            errors++;
        end
    endfunction
endclass

module pressure_temp_compensation_tb;
    import ptc_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    longint cycles = 0;

    ptc_stream_if #(.T(ptc_in_t)) in_ch ();
    ptc_stream_if #(.T(ptc_out_t)) out_ch ();

    comp_scoreboard board;

    pressure_temp_compensation u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_s(in_ch.sink),
        .out_s(out_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.data);
        if (!rst_n || hold_off)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        wait (cycles > 64'd2000000);
        $display("FAILURE");
        $finish;
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_TEMP_COEFFS: board.tc = val[47:0];
            REG_PRESS_A: board.pa = val;
            REG_PRESS_B: board.pb = val;
            default: board.p9c = val[15:0];
        endcase
    endtask

    task automatic send_sample(input logic [19:0] t, input logic [19:0] p);
        ptc_in_t s;
        s.temp_sample = t;
        s.press_sample = p;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= s;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_sample(s);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Loads a calibration by mode: typical factory values, all ones, extremes, random or randomized slices.
    task automatic load_calibration(input int mode);
        logic [63:0] r;
        r = {$urandom, $urandom};
        case (mode)
            0:
            begin
                write_reg(REG_TEMP_COEFFS, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
                write_reg(REG_PRESS_A, {16'd2855, 16'hFFFF & -16'd5, 16'hD4BD, 16'd36477});
                write_reg(REG_PRESS_B, {16'hFF & 16'd0, 16'hFFF9 & -16'd7, 16'hFF88, 16'd140}
                          | {16'hC0B8, 48'd0} | {16'd0, 16'd15500, 32'd0});
                write_reg(REG_PRESS_NINE, 64'd6000);
            end
            1:
            begin
                write_reg(REG_TEMP_COEFFS, 64'h0000_0000_FFFF_FFFF);
                write_reg(REG_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
                write_reg(REG_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
                write_reg(REG_PRESS_NINE, 64'hFFFF);
            end
            2:
            begin
                write_reg(REG_TEMP_COEFFS, 64'h0000_7FFF_8000_7FFF);
                write_reg(REG_PRESS_A, 64'h8000_7FFF_8000_0001);
                write_reg(REG_PRESS_B, 64'h7FFF_8000_7FFF_8000);
                write_reg(REG_PRESS_NINE, 64'h8000);
            end
            3:
            begin
                write_reg(REG_TEMP_COEFFS, {r[63:48], 48'd0} | {16'd0, r[47:0]});
                write_reg(REG_PRESS_A, {$urandom, $urandom});
                write_reg(REG_PRESS_B, {$urandom, $urandom});
                write_reg(REG_PRESS_NINE, {$urandom, $urandom});
            end
            default:
            begin
                write_reg(REG_TEMP_COEFFS, {16'd0, 16'(-$urandom_range(1000)),
                                            16'($urandom_range(30000)), 16'd27504});
                write_reg(REG_PRESS_A, {16'($urandom_range(8000)),
                                        16'(-$urandom_range(20000)),
                                        16'($urandom_range(65535)), 16'($urandom_range(65535))});
                write_reg(REG_PRESS_B, {$urandom, $urandom});
                write_reg(REG_PRESS_NINE, 64'($urandom_range(65535)));
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int ph;
        int n;
        logic [19:0] t;
        logic [19:0] p;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        @(posedge rst_n);
        @(posedge clk);
        // Zero calibration gives a zero divisor; then the extremes of the fields.
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        drain();
        load_calibration(0);
        send_sample(20'd519888, 20'd415148);
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'hAAAAA, 20'h55555);
        send_sample(20'h55555, 20'hAAAAA);
        send_sample(20'd0, 20'hFFFFF);
        drain();
        load_calibration(1);
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h80000, 20'd1);
        drain();
        load_calibration(2);
        send_sample(20'd0, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'd0);
        send_sample(20'h7FFFF, 20'h80000);
        drain();
        // Random phases with different flow control and calibration.
        for (ph = 0; ph < 10; ph++)
        begin
            load_calibration(ph < 4 ? 0 : 3 + (ph % 2));
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 65; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 65; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            if (ph == 1)
            begin
                send_idle_pct = 0;
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (n = 0; n < 150; n++)
            begin
                if ($urandom_range(3) == 0)
                begin
                    t = 20'($urandom);
                    p = 20'($urandom);
                end
                else
                begin
                    t = 20'($urandom_range(600000, 400000));
                    p = 20'($urandom_range(500000, 250000));
                end
                send_sample(t, p);
            end
            drain();
        end
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
